// ===== hw/rtl/rzh_pkg.sv =====
// Shared types, codes and helpers for the rectangle zone hit table.
package rzh_pkg;

	// Default number of zone slots per screen
	localparam int ZONE_SLOTS_DEF = 32;

	// Field widths fixed by the interface
	localparam int COORD_W   = 16;
	localparam int ZONE_W    = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;
	localparam int BOX_W     = 4 * COORD_W;

	// Reset values of the configuration registers
	localparam logic [COORD_W-1:0] PANEL_Y_OFFSET_RST    = COORD_W'(150);
	localparam logic [ZONE_W-1:0]  OBJECT_ZONE_COUNT_RST = '0;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PANEL_Y_OFFSET    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_OBJECT_ZONE_COUNT = CFG_IDX_W'(1);

	// Transaction action codes
	typedef enum logic [1:0] {
		ACT_SET   = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_FIND  = 2'd2
	} action_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HOLD
	} seq_state_t;

	// Write-side control from sequencer to zone memory
	typedef struct packed {
		logic set;
		logic clear;
		logic screen;
	} mem_ctl_t;

	// Box is packed {left, top, right, bottom}
	function automatic logic box_holds(input logic [BOX_W-1:0] box,
			input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
		logic [COORD_W-1:0] l;
		logic [COORD_W-1:0] t;
		logic [COORD_W-1:0] r;
		logic [COORD_W-1:0] b;
		l = box[4*COORD_W-1:3*COORD_W];
		t = box[3*COORD_W-1:2*COORD_W];
		r = box[2*COORD_W-1:COORD_W];
		b = box[COORD_W-1:0];
		return (l <= x) && (x <= r) && (t <= y) && (y <= b);
	endfunction

endpackage

// ===== hw/rtl/rzh_zone_mem.sv =====
// Zone box memory for both screens plus per-slot valid flags.
module rzh_zone_mem import rzh_pkg::*; #(
	parameter int ZONE_SLOTS = ZONE_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mem_ctl_t                      ctl,
	input  logic [$clog2(ZONE_SLOTS)-1:0] wr_slot,
	input  logic [BOX_W-1:0]              wr_box,
	input  logic                          rd_en,
	input  logic                          rd_screen,
	input  logic [$clog2(ZONE_SLOTS)-1:0] rd_slot,
	output logic [BOX_W-1:0]              rd_box,
	output logic                          rd_valid
);

	localparam int SLOT_W = $clog2(ZONE_SLOTS);
	localparam int ADDR_W = SLOT_W + 1;
	localparam int DEPTH  = 2 ** ADDR_W;
	localparam int PER_SCR = 2 ** SLOT_W;

	logic [BOX_W-1:0] box_mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [BOX_W-1:0] rd_box_q;
	logic             rd_valid_q;

	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;

	assign wr_addr = {ctl.screen, wr_slot};
	assign rd_addr = {rd_screen, rd_slot};

	// Box storage: written on set, read through a registered output.
	// Writes happen only while idle and reads only during a scan, so
	// the two never touch the same entry in one cycle.
	always_ff @(posedge clk) begin
		if (ctl.set) begin
			box_mem[wr_addr] <= wr_box;
		end
		if (rd_en) begin
			rd_box_q <= box_mem[rd_addr];
		end
	end

	// Valid flags: set marks one slot, clear drops slots 1 and up of a screen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctl.set) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (ctl.clear) begin
				for (int i = 1; i < PER_SCR; i++) begin
					valid_q[{ctl.screen, SLOT_W'(i)}] <= 1'b0;
				end
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_box   = rd_box_q;
	assign rd_valid = rd_valid_q;

endmodule

// ===== hw/rtl/rzh_seq.sv =====
// Transaction sequencer: decodes actions, walks zone slots for finds.
module rzh_seq import rzh_pkg::*; #(
	parameter int ZONE_SLOTS = ZONE_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input channel (control and find fields)
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    action,
	input  logic                          screen_sel,
	input  logic [ZONE_W-1:0]             zone_index,
	input  logic [COORD_W-1:0]            point_x,
	input  logic [COORD_W-1:0]            point_y,
	// configuration
	input  logic [COORD_W-1:0]            panel_y_offset,
	input  logic [ZONE_W-1:0]             object_zone_count,
	// zone memory
	output mem_ctl_t                      mem_ctl,
	output logic [$clog2(ZONE_SLOTS)-1:0] wr_slot,
	output logic                          rd_en,
	output logic                          rd_screen,
	output logic [$clog2(ZONE_SLOTS)-1:0] rd_slot,
	input  logic [BOX_W-1:0]              rd_box,
	input  logic                          rd_valid,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ZONE_W-1:0]             hit_zone,
	output logic [ZONE_W-1:0]             hit_area
);

	localparam int SLOT_W = $clog2(ZONE_SLOTS);
	localparam int CNT_W  = SLOT_W + 1;
	localparam int HIT_W  = (SLOT_W > ZONE_W) ? SLOT_W : ZONE_W;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ZONE_SLOTS - 1);

	seq_state_t state_q, state_d;

	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic               scr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               pend_s1;
	logic [SLOT_W-1:0]  slot_s1;
	logic [SLOT_W-1:0]  hit_q;
	logic               out_valid_q;
	logic [ZONE_W-1:0]  hit_zone_q;
	logic [ZONE_W-1:0]  hit_area_q;

	action_t           act;
	logic              accept;
	logic              find_go;
	logic              match;
	logic              scan_done;
	logic              out_load;
	logic [HIT_W-1:0]  hit_ext;
	logic [HIT_W-1:0]  ozc_ext;
	logic [ZONE_W-1:0] area_d;

	assign act     = action_t'(action);
	assign accept  = in_valid && in_ready;
	assign find_go = accept && (act == ACT_FIND);

	// Slot comparison in the cycle after each read
	assign match     = pend_s1 && rd_valid && box_holds(rd_box, x_q, y_q);
	assign scan_done = pend_s1 && (match || (slot_s1 == LAST_SLOT));
	assign out_load  = (state_q == ST_HOLD) && (!out_valid_q || out_ready);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (find_go) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_SCAN: rd_en    = (cnt_q < CNT_W'(ZONE_SLOTS));
			ST_HOLD: ;
			default: ;
		endcase
	end

	// Memory write control, only from accepted set and clear transactions
	assign mem_ctl.set   = accept && (act == ACT_SET) && (32'(zone_index) < ZONE_SLOTS);
	assign mem_ctl.clear = accept && (act == ACT_CLEAR);
	assign mem_ctl.screen = screen_sel;
	assign wr_slot   = SLOT_W'(zone_index);
	assign rd_screen = scr_q;
	assign rd_slot   = cnt_q[SLOT_W-1:0];

	// Area number from the hit slot
	assign hit_ext = HIT_W'(hit_q);
	assign ozc_ext = HIT_W'(object_zone_count);
	assign area_d  = (hit_ext > ozc_ext) ? ZONE_W'(hit_ext - ozc_ext) : '0;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (find_go) begin
				cnt_q   <= CNT_W'(1);
				pend_s1 <= 1'b0;
			end else begin
				if (rd_en) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				pend_s1 <= rd_en && !scan_done;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Find operands, scan pipeline and result payload
	always_ff @(posedge clk) begin
		if (find_go) begin
			x_q   <= point_x;
			y_q   <= screen_sel ? (point_y - panel_y_offset) : point_y;
			scr_q <= screen_sel;
		end
		slot_s1 <= cnt_q[SLOT_W-1:0];
		if ((state_q == ST_SCAN) && scan_done) begin
			hit_q <= match ? slot_s1 : '0;
		end
		if (out_load) begin
			hit_zone_q <= ZONE_W'(hit_ext);
			hit_area_q <= area_d;
		end
	end

	assign out_valid = out_valid_q;
	assign hit_zone  = hit_zone_q;
	assign hit_area  = hit_area_q;

endmodule

// ===== hw/rtl/rectangle_zone_hit_table.sv =====
// Top level of the rectangle zone hit table: configuration and wiring.
//
// Input channel (in_valid/in_ready) carries one transaction per item:
// set writes one zone box and marks it valid, clear drops zones 1 and up
// of one screen, find looks up a point. Only finds produce a result on
// the output channel (out_valid/out_ready): hit_zone and hit_area.
// A find walks the slots of its screen from slot 1 up, one per cycle,
// through the box memory's single read port, stopping at the first hit.
// One item is handled at a time; in_ready is low during a find. The
// result sits in an output register, so the next item is accepted while
// it waits; a find that finishes while the previous result is still
// stalled holds until the output register frees up.
// Configuration (cfg_we/cfg_index/cfg_data) is to be written by the user
// only while idle; the block itself does not enforce it.
// Reset clears all valid flags at once and loads the register defaults;
// the box memory needs no clearing since unwritten slots are never valid.
module rectangle_zone_hit_table import rzh_pkg::*; #(
	parameter int ZONE_SLOTS = ZONE_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           action,
	input  logic                 screen_sel,
	input  logic [ZONE_W-1:0]    zone_index,
	input  logic [COORD_W-1:0]   box_left,
	input  logic [COORD_W-1:0]   box_top,
	input  logic [COORD_W-1:0]   box_right,
	input  logic [COORD_W-1:0]   box_bottom,
	input  logic [COORD_W-1:0]   point_x,
	input  logic [COORD_W-1:0]   point_y,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ZONE_W-1:0]    hit_zone,
	output logic [ZONE_W-1:0]    hit_area,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int SLOT_W = $clog2(ZONE_SLOTS);

	logic [COORD_W-1:0] panel_y_offset_q;
	logic [ZONE_W-1:0]  object_zone_count_q;

	mem_ctl_t          mem_ctl;
	logic [SLOT_W-1:0] wr_slot;
	logic              rd_en;
	logic              rd_screen;
	logic [SLOT_W-1:0] rd_slot;
	logic [BOX_W-1:0]  rd_box;
	logic              rd_valid;
	logic [BOX_W-1:0]  wr_box;

	// Configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_y_offset_q    <= PANEL_Y_OFFSET_RST;
			object_zone_count_q <= OBJECT_ZONE_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PANEL_Y_OFFSET:    panel_y_offset_q    <= cfg_data;
				REG_OBJECT_ZONE_COUNT: object_zone_count_q <= cfg_data[ZONE_W-1:0];
				default: ;
			endcase
		end
	end

	assign wr_box = {box_left, box_top, box_right, box_bottom};

	rzh_seq #(
		.ZONE_SLOTS(ZONE_SLOTS)
	) u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.action           (action),
		.screen_sel       (screen_sel),
		.zone_index       (zone_index),
		.point_x          (point_x),
		.point_y          (point_y),
		.panel_y_offset   (panel_y_offset_q),
		.object_zone_count(object_zone_count_q),
		.mem_ctl          (mem_ctl),
		.wr_slot          (wr_slot),
		.rd_en            (rd_en),
		.rd_screen        (rd_screen),
		.rd_slot          (rd_slot),
		.rd_box           (rd_box),
		.rd_valid         (rd_valid),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.hit_zone         (hit_zone),
		.hit_area         (hit_area)
	);

	rzh_zone_mem #(
		.ZONE_SLOTS(ZONE_SLOTS)
	) u_zone_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mem_ctl),
		.wr_slot  (wr_slot),
		.wr_box   (wr_box),
		.rd_en    (rd_en),
		.rd_screen(rd_screen),
		.rd_slot  (rd_slot),
		.rd_box   (rd_box),
		.rd_valid (rd_valid)
	);

endmodule

// ===== test/tb_rectangle_zone_hit_table.sv =====
`timescale 1ns / 100ps
// Testbench for the rectangle zone hit table: directed and random traffic checked per result.
module tb_rectangle_zone_hit_table;
	import rzh_pkg::*;

	localparam int SLOTS         = ZONE_SLOTS_DEF;
	localparam int SETTLE_CYCLES = SLOTS + 8;
	localparam int STALL_LIMIT   = 2000;
	localparam int PHASE_ITEMS   = 150;

	// Codes outside the defined sets, used to probe ignored inputs
	localparam logic [1:0]           ACT_UNUSED  = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

	typedef struct packed {
		logic [COORD_W-1:0] left, top, right, bottom;
	} zone_rect_t;

	typedef struct packed {
		logic [1:0]         act;
		logic               scr;
		logic [ZONE_W-1:0]  idx;
		zone_rect_t         box;
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
	} zone_req_t;

	typedef struct packed {
		logic [ZONE_W-1:0] zone;
		logic [ZONE_W-1:0] area;
	} hit_result_t;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 in_valid   = 1'b0;
	logic                 in_ready;
	logic [1:0]           action     = '0;
	logic                 screen_sel = 1'b0;
	logic [ZONE_W-1:0]    zone_index = '0;
	logic [COORD_W-1:0]   box_left   = '0;
	logic [COORD_W-1:0]   box_top    = '0;
	logic [COORD_W-1:0]   box_right  = '0;
	logic [COORD_W-1:0]   box_bottom = '0;
	logic [COORD_W-1:0]   point_x    = '0;
	logic [COORD_W-1:0]   point_y    = '0;
	logic                 out_valid;
	logic                 out_ready  = 1'b0;
	logic [ZONE_W-1:0]    hit_zone;
	logic [ZONE_W-1:0]    hit_area;
	logic                 cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index  = '0;
	logic [CFG_DAT_W-1:0] cfg_data   = '0;

	// Shadow copy of the zone tables and registers
	logic               zone_live [2][SLOTS];
	zone_rect_t         zone_rect [2][SLOTS];
	logic [COORD_W-1:0] panel_offset = PANEL_Y_OFFSET_RST;
	logic [ZONE_W-1:0]  object_count = OBJECT_ZONE_COUNT_RST;
	hit_result_t        pending_hits [$];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int mismatch_count = 0;
	int stall_cycles = 0;

	rectangle_zone_hit_table uut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver backpressure
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	task automatic report_mismatch(input string what, input logic [ZONE_W-1:0] got,
			input logic [ZONE_W-1:0] want);
		$display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// First live slot from 1 up that holds the point, plus its area number
	function automatic hit_result_t lookup_point(input logic scr,
			input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
		hit_result_t        res;
		logic [COORD_W-1:0] yy;
		zone_rect_t         r;
		res = '0;
		yy = scr ? COORD_W'(y - panel_offset) : y;
		for (int i = 1; i < SLOTS; i++) begin
			r = zone_rect[scr][i];
			if (zone_live[scr][i] && r.left <= x && x <= r.right &&
					r.top <= yy && yy <= r.bottom) begin
				res.zone = ZONE_W'(i);
				break;
			end
		end
		if (res.zone > object_count)
			res.area = res.zone - object_count;
		return res;
	endfunction

	// Apply one accepted transaction to the shadow tables
	function automatic void apply_item(input zone_req_t req);
		case (req.act)
			ACT_SET: begin
				if (req.idx < SLOTS) begin
					zone_live[req.scr][req.idx] = 1'b1;
					zone_rect[req.scr][req.idx] = req.box;
				end
			end
			ACT_CLEAR: begin
				for (int i = 1; i < SLOTS; i++)
					zone_live[req.scr][i] = 1'b0;
			end
			ACT_FIND: begin
				pending_hits.push_back(lookup_point(req.scr, req.px, req.py));
			end
			default: ;
		endcase
	endfunction

	// Result check, input tracking and register tracking
	always @(posedge clk) begin : port_monitor
		zone_req_t   seen;
		hit_result_t want;
		if (out_valid && out_ready) begin
			if (pending_hits.size() == 0) begin
				report_mismatch("unexpected result, hit_zone", hit_zone, '0);
			end else begin
				want = pending_hits.pop_front();
				if (hit_zone !== want.zone)
					report_mismatch("hit_zone", hit_zone, want.zone);
				if (hit_area !== want.area)
					report_mismatch("hit_area", hit_area, want.area);
			end
		end
		if (in_valid && in_ready) begin
			seen.act = action;
			seen.scr = screen_sel;
			seen.idx = zone_index;
			seen.box = {box_left, box_top, box_right, box_bottom};
			seen.px = point_x;
			seen.py = point_y;
			apply_item(seen);
		end
		if (cfg_we) begin
			case (cfg_index)
				REG_PANEL_Y_OFFSET:    panel_offset = cfg_data;
				REG_OBJECT_ZONE_COUNT: object_count = cfg_data[ZONE_W-1:0];
				default: ;
			endcase
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic send_item(input zone_req_t req);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		action     <= req.act;
		screen_sel <= req.scr;
		zone_index <= req.idx;
		box_left   <= req.box.left;
		box_top    <= req.box.top;
		box_right  <= req.box.right;
		box_bottom <= req.box.bottom;
		point_x    <= req.px;
		point_y    <= req.py;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Hold off input until every result is back and the block has settled
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_hits.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Transaction with every field random
	function automatic zone_req_t noise_req();
		logic [127:0] bits;
		bits = {$urandom(), $urandom(), $urandom(), $urandom()};
		return bits[$bits(zone_req_t)-1:0];
	endfunction

	function automatic zone_req_t set_req(input logic scr, input logic [ZONE_W-1:0] idx,
			input zone_rect_t box);
		zone_req_t r;
		r = noise_req();
		r.act = ACT_SET;
		r.scr = scr;
		r.idx = idx;
		r.box = box;
		return r;
	endfunction

	function automatic zone_req_t find_req(input logic scr, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y);
		zone_req_t r;
		r = noise_req();
		r.act = ACT_FIND;
		r.scr = scr;
		r.px = x;
		r.py = y;
		return r;
	endfunction

	function automatic zone_req_t clear_req(input logic scr);
		zone_req_t r;
		r = noise_req();
		r.act = ACT_CLEAR;
		r.scr = scr;
		return r;
	endfunction

	function automatic zone_rect_t make_rect(input int l, input int t, input int r, input int b);
		zone_rect_t z;
		z.left = COORD_W'(l);
		z.top = COORD_W'(t);
		z.right = COORD_W'(r);
		z.bottom = COORD_W'(b);
		return z;
	endfunction

	// Far bound of a box, saturated at the top of the coordinate range
	function automatic logic [COORD_W-1:0] grow_from(input logic [COORD_W-1:0] base);
		logic [COORD_W:0] far_bound;
		far_bound = {1'b0, base} + (COORD_W+1)'($urandom_range(0, 255));
		return far_bound[COORD_W] ? '1 : far_bound[COORD_W-1:0];
	endfunction

	function automatic logic [COORD_W-1:0] rand_coord();
		return $urandom_range(0, 1) ? COORD_W'($urandom_range(0, 1023)) : COORD_W'($urandom());
	endfunction

	// Mostly small boxes, many placed near the origin so they overlap
	function automatic zone_rect_t rand_box();
		zone_rect_t b;
		int         pick;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			b = {$urandom(), $urandom()};
		end else if (pick < 13) begin
			b = make_rect(0, 0, 65535, 65535);
		end else begin
			b.left = (pick < 60) ? COORD_W'($urandom_range(0, 1023)) : COORD_W'($urandom());
			b.top = (pick < 60) ? COORD_W'($urandom_range(0, 1023)) : COORD_W'($urandom());
			b.right = grow_from(b.left);
			b.bottom = grow_from(b.top);
		end
		return b;
	endfunction

	// Find aimed at a point inside some slot's box where that slot is live, else at a random point
	function automatic zone_req_t aimed_find();
		logic               scr;
		int                 slot;
		zone_rect_t         b;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		scr = 1'($urandom_range(0, 1));
		slot = $urandom_range(1, SLOTS - 1);
		b = zone_rect[scr][slot];
		if (zone_live[scr][slot] && b.left <= b.right && b.top <= b.bottom) begin
			x = COORD_W'($urandom_range(b.left, b.right));
			y = COORD_W'($urandom_range(b.top, b.bottom));
		end else begin
			x = rand_coord();
			y = rand_coord();
		end
		if (scr)
			y = y + panel_offset;
		return find_req(scr, x, y);
	endfunction

	function automatic zone_req_t random_req();
		zone_req_t r;
		int        pick;
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			r = noise_req();
			r.act = ACT_UNUSED;
		end else if (pick < 6) begin
			r = clear_req(1'($urandom_range(0, 1)));
		end else if (pick < 40) begin
			r = set_req(1'($urandom_range(0, 1)), ZONE_W'($urandom_range(0, SLOTS - 1)),
					rand_box());
		end else if (pick < 85) begin
			r = aimed_find();
		end else begin
			r = find_req(1'($urandom_range(0, 1)), rand_coord(), rand_coord());
		end
		return r;
	endfunction

	// New register settings, extremes included
	task automatic pick_config();
		int                 pick;
		logic [COORD_W-1:0] offset;
		logic [ZONE_W-1:0]  count;
		pick = $urandom_range(0, 99);
		offset = (pick < 20) ? COORD_W'(0) : (pick < 40) ? '1 : rand_coord();
		pick = $urandom_range(0, 99);
		count = (pick < 15) ? ZONE_W'(0) : (pick < 30) ? '1 : ZONE_W'($urandom());
		write_reg(REG_PANEL_Y_OFFSET, offset);
		write_reg(REG_OBJECT_ZONE_COUNT, CFG_DAT_W'(count));
		if ($urandom_range(0, 9) == 0)
			write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_DAT_W'($urandom()));
	endtask

	task automatic test_empty_tables();
		send_item(find_req(1'b0, 16'd0, 16'd0));
		send_item(find_req(1'b1, 16'hFFFF, 16'hFFFF));
	endtask

	// Slot zero is never reported; bounds are inclusive
	task automatic test_slot_zero_and_bounds();
		send_item(set_req(1'b0, 5'd0, make_rect(0, 0, 65535, 65535)));
		send_item(find_req(1'b0, 16'd100, 16'd100));
		send_item(set_req(1'b0, 5'd31, make_rect(0, 0, 65535, 65535)));
		send_item(find_req(1'b0, 16'd0, 16'd0));
		send_item(find_req(1'b0, 16'hFFFF, 16'hFFFF));
		send_item(set_req(1'b0, 5'd3, make_rect(10, 20, 30, 40)));
		send_item(find_req(1'b0, 16'd10, 16'd20));
		send_item(find_req(1'b0, 16'd30, 16'd40));
		send_item(find_req(1'b0, 16'd31, 16'd40));
	endtask

	// Inverted box never hits; lowest overlapping slot wins
	task automatic test_overlap_and_inverted();
		send_item(set_req(1'b0, 5'd2, make_rect(50, 0, 40, 65535)));
		send_item(find_req(1'b0, 16'd45, 16'd10));
		send_item(set_req(1'b0, 5'd1, make_rect(10, 20, 30, 40)));
		send_item(find_req(1'b0, 16'd15, 16'd25));
	endtask

	// Panel lookup with y below the offset wraps around
	task automatic test_panel_wrap();
		send_item(set_req(1'b1, 5'd7, make_rect(0, 65500, 100, 65535)));
		send_item(find_req(1'b1, 16'd50, 16'd120));
		send_item(find_req(1'b1, 16'd50, 16'd160));
	endtask

	// Clears drop slots 1 and up of one screen; unused action does nothing
	task automatic test_clear_and_unused();
		zone_req_t r;
		r = noise_req();
		r.act = ACT_UNUSED;
		send_item(r);
		send_item(clear_req(1'b0));
		send_item(find_req(1'b0, 16'd15, 16'd25));
		send_item(find_req(1'b1, 16'd50, 16'd120));
		send_item(clear_req(1'b1));
		send_item(find_req(1'b1, 16'd50, 16'd120));
	endtask

	task automatic test_register_extremes();
		wait_idle();
		write_reg(REG_PANEL_Y_OFFSET, '0);
		write_reg(REG_OBJECT_ZONE_COUNT, CFG_DAT_W'(31));
		write_reg(REG_SPARE_A, '1);
		write_reg(REG_SPARE_B, '1);
		send_item(set_req(1'b0, 5'd5, make_rect(0, 0, 65535, 65535)));
		send_item(find_req(1'b0, 16'd7, 16'd7));
		send_item(set_req(1'b1, 5'd30, make_rect(0, 0, 10, 10)));
		send_item(find_req(1'b1, 16'd5, 16'd5));
		wait_idle();
		write_reg(REG_PANEL_Y_OFFSET, '1);
		write_reg(REG_OBJECT_ZONE_COUNT, '0);
		send_item(find_req(1'b1, 16'd5, 16'd4));
		send_item(find_req(1'b0, 16'hFFFF, 16'd0));
	endtask

	// Random traffic in phases, each opened on an idle block with new settings
	task automatic test_random_traffic(input int n_items);
		for (int k = 0; k < n_items; k++) begin
			if (k % PHASE_ITEMS == 0) begin
				wait_idle();
				pick_config();
			end
			send_item(random_req());
		end
	endtask

	initial begin
		for (int s = 0; s < 2; s++) begin
			for (int i = 0; i < SLOTS; i++) begin
				zone_live[s][i] = 1'b0;
				zone_rect[s][i] = '0;
			end
		end
		tx_idle_pct = 23;
		rx_idle_pct = 51;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_tables();
		test_slot_zero_and_bounds();
		test_overlap_and_inverted();
		test_panel_wrap();
		test_clear_and_unused();
		test_register_extremes();
		test_random_traffic(600);

		tx_idle_pct = 51;
		rx_idle_pct = 23;
		test_random_traffic(600);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_traffic(600);

		wait_idle();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/rzh_pkg.sv
hw/rtl/rzh_zone_mem.sv
hw/rtl/rzh_seq.sv
hw/rtl/rectangle_zone_hit_table.sv
test/tb_rectangle_zone_hit_table.sv
